// ----- rtl/core/pcsc_pkg.sv -----
// Shared types and constants for the pixel cluster shape classifier.
// Holds the coordinate widths, the shape codes and the cluster summary record.
// No dependencies.
package pcsc_pkg;

	// Coordinate widths and derived accumulator widths.
	localparam int U_BITS  = 8;
	localparam int V_BITS  = 10;
	localparam int SU_BITS = U_BITS + 2;
	localparam int SV_BITS = V_BITS + 2;

	// Pixel count saturates at five; sums cover the first three pixels.
	localparam int CNT_BITS = 3;
	localparam logic [CNT_BITS-1:0] CNT_SAT    = CNT_BITS'(5);
	localparam logic [CNT_BITS-1:0] SUM_TERMS  = CNT_BITS'(3);
	localparam logic [CNT_BITS-1:0] CNT_ONE    = CNT_BITS'(1);
	localparam logic [CNT_BITS-1:0] CNT_TWO    = CNT_BITS'(2);
	localparam logic [CNT_BITS-1:0] CNT_THREE  = CNT_BITS'(3);
	localparam logic [CNT_BITS-1:0] CNT_FOUR   = CNT_BITS'(4);

	// Depth of the summary queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// Shape codes.
	typedef enum logic [3:0] {
		SHAPE_NONE      = 4'd0,
		SHAPE_SINGLE    = 4'd1,
		SHAPE_2X1       = 4'd2,
		SHAPE_1X2       = 4'd3,
		SHAPE_DIAG      = 4'd4,
		SHAPE_ANTIDIAG  = 4'd5,
		SHAPE_NX1       = 4'd6,
		SHAPE_1XM       = 4'd7,
		SHAPE_NX2       = 4'd8,
		SHAPE_2XM       = 4'd9,
		SHAPE_2X2       = 4'd10,
		SHAPE_L         = 4'd11,
		SHAPE_L_MIR_U   = 4'd12,
		SHAPE_L_MIR_V   = 4'd13,
		SHAPE_L_MIR_UV  = 4'd14,
		SHAPE_EXTENDED  = 4'd15
	} shape_t;

	// Everything the back part needs to classify one finished cluster.
	typedef struct packed {
		logic [CNT_BITS-1:0] count;
		logic [U_BITS-1:0]   first_u;
		logic [V_BITS-1:0]   first_v;
		logic [SU_BITS-1:0]  sum_u;
		logic [SV_BITS-1:0]  sum_v;
		logic [U_BITS-1:0]   min_u;
		logic [U_BITS-1:0]   max_u;
		logic [V_BITS-1:0]   min_v;
		logic [V_BITS-1:0]   max_v;
	} cluster_sum_t;

	// Queue status seen by the front and back parts.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ----- rtl/core/pcsc_front.sv -----
// Front part of the shape classifier: accepts pixels and accumulates one cluster.
// Pushes a cluster summary into the queue on the last pixel.
// Depends on pcsc_pkg.
module pcsc_front
	import pcsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [U_BITS-1:0]   pixel_u,
	input  logic [V_BITS-1:0]   pixel_v,
	input  logic                last_pixel,
	input  queue_stat_t         q_stat,
	output logic                push,
	output cluster_sum_t        push_sum
);

	logic [CNT_BITS-1:0] cnt_q;
	logic [U_BITS-1:0]   first_u_q;
	logic [V_BITS-1:0]   first_v_q;
	logic [SU_BITS-1:0]  sum_u_q;
	logic [SV_BITS-1:0]  sum_v_q;
	logic [U_BITS-1:0]   min_u_q;
	logic [U_BITS-1:0]   max_u_q;
	logic [V_BITS-1:0]   min_v_q;
	logic [V_BITS-1:0]   max_v_q;

	logic         accept;
	cluster_sum_t nxt;

	// A pixel is taken whenever the queue has room for a possible summary.
	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;

	// Cluster state including the pixel now on the input.
	always_comb begin
		nxt.count   = (cnt_q < CNT_SAT) ? cnt_q + CNT_ONE : cnt_q;
		nxt.first_u = (cnt_q == '0) ? pixel_u : first_u_q;
		nxt.first_v = (cnt_q == '0) ? pixel_v : first_v_q;
		nxt.sum_u   = (cnt_q < SUM_TERMS) ? sum_u_q + SU_BITS'(pixel_u) : sum_u_q;
		nxt.sum_v   = (cnt_q < SUM_TERMS) ? sum_v_q + SV_BITS'(pixel_v) : sum_v_q;
		nxt.min_u   = (pixel_u < min_u_q) ? pixel_u : min_u_q;
		nxt.max_u   = (pixel_u > max_u_q) ? pixel_u : max_u_q;
		nxt.min_v   = (pixel_v < min_v_q) ? pixel_v : min_v_q;
		nxt.max_v   = (pixel_v > max_v_q) ? pixel_v : max_v_q;
	end

	assign push     = accept && last_pixel;
	assign push_sum = nxt;

	// Accumulators; the last pixel of a cluster returns them to the empty state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			first_u_q <= '0;
			first_v_q <= '0;
			sum_u_q   <= '0;
			sum_v_q   <= '0;
			min_u_q   <= '1;
			max_u_q   <= '0;
			min_v_q   <= '1;
			max_v_q   <= '0;
		end else if (accept) begin
			if (last_pixel) begin
				cnt_q     <= '0;
				first_u_q <= '0;
				first_v_q <= '0;
				sum_u_q   <= '0;
				sum_v_q   <= '0;
				min_u_q   <= '1;
				max_u_q   <= '0;
				min_v_q   <= '1;
				max_v_q   <= '0;
			end else begin
				cnt_q     <= nxt.count;
				first_u_q <= nxt.first_u;
				first_v_q <= nxt.first_v;
				sum_u_q   <= nxt.sum_u;
				sum_v_q   <= nxt.sum_v;
				min_u_q   <= nxt.min_u;
				max_u_q   <= nxt.max_u;
				min_v_q   <= nxt.min_v;
				max_v_q   <= nxt.max_v;
			end
		end
	end

	// The count never passes its saturation point.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_SAT)
		else $error("pixel count above saturation");

	// A finished cluster leaves the accumulators empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (cnt_q == '0) && (min_u_q == '1) && (max_v_q == '0))
		else $error("cluster state not cleared after last pixel");

	// A summary always counts at least the pixel that closes it.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> (push_sum.count != '0))
		else $error("summary pushed with zero pixels");

endmodule

// ----- rtl/core/pcsc_queue.sv -----
// Short queue of cluster summaries between the front and back parts.
// Lets the pixel input and the result output stall independently.
// Depends on pcsc_pkg.
module pcsc_queue
	import pcsc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  cluster_sum_t push_sum,
	input  logic         pop,
	output cluster_sum_t head,
	output queue_stat_t  stat
);

	cluster_sum_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;

	assign stat.full  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = mem_q[rd_ptr_q];

	// Storage; entries carry no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_sum;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_BITS'(1);
			end
		end
	end

	// No write into a full queue, no read from an empty one.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !stat.full)
		else $error("push into full queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !stat.empty)
		else $error("pop from empty queue");

	// Pointer distance agrees with the fill level.
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == QPTR_BITS'(cnt_q))
		else $error("queue pointers disagree with fill level");

endmodule

// ----- rtl/core/pcsc_back.sv -----
// Back part of the shape classifier: classifies the summary at the queue head.
// Holds the shape code in an output register until the receiver takes it.
// Depends on pcsc_pkg.
module pcsc_back
	import pcsc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cluster_sum_t head,
	input  queue_stat_t  q_stat,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [3:0]   shape_code
);

	logic        out_valid_q;
	shape_t      code_q;
	shape_t      code;

	logic [U_BITS-1:0]  diff_u;
	logic [V_BITS-1:0]  diff_v;
	logic [SU_BITS-1:0] ku;
	logic [SV_BITS-1:0] kv;
	logic eu1, eu2, ev1, ev2;
	logic mu, mv, diag, ext22;
	shape_t by_ext;

	// Extents: max is never below min once a pixel has been counted.
	assign diff_u = head.max_u - head.min_u;
	assign diff_v = head.max_v - head.min_v;
	assign eu1    = (diff_u == '0);
	assign eu2    = (diff_u == U_BITS'(1));
	assign ev1    = (diff_v == '0);
	assign ev2    = (diff_v == V_BITS'(1));
	assign ext22  = eu2 && ev2;

	// Pixels at the maximum along each axis of an L: sum minus three times min.
	assign ku = head.sum_u - (SU_BITS'({head.min_u, 1'b0}) + SU_BITS'(head.min_u));
	assign kv = head.sum_v - (SV_BITS'({head.min_v, 1'b0}) + SV_BITS'(head.min_v));
	assign mu = (ku == SU_BITS'(1));
	assign mv = (kv == SV_BITS'(1));

	// Two pixels run diagonally when the first one is the lower in both axes.
	assign diag = (SU_BITS'({head.first_u, 1'b0}) < head.sum_u) &&
		(SV_BITS'({head.first_v, 1'b0}) < head.sum_v);

	// Classification by extents alone.
	always_comb begin
		if (ev1) begin
			by_ext = SHAPE_NX1;
		end else if (eu1) begin
			by_ext = SHAPE_1XM;
		end else if (ev2) begin
			by_ext = SHAPE_NX2;
		end else if (eu2) begin
			by_ext = SHAPE_2XM;
		end else begin
			by_ext = SHAPE_EXTENDED;
		end
	end

	// Full shape decision.
	always_comb begin
		if (head.count == CNT_ONE) begin
			code = SHAPE_SINGLE;
		end else if (head.count == CNT_TWO) begin
			if (eu2 && ev1) begin
				code = SHAPE_2X1;
			end else if (eu1 && ev2) begin
				code = SHAPE_1X2;
			end else if (diag) begin
				code = SHAPE_DIAG;
			end else begin
				code = SHAPE_ANTIDIAG;
			end
		end else if (head.count == CNT_THREE && ext22) begin
			if (mu && mv) begin
				code = SHAPE_L;
			end else if (mv) begin
				code = SHAPE_L_MIR_U;
			end else if (mu) begin
				code = SHAPE_L_MIR_V;
			end else begin
				code = SHAPE_L_MIR_UV;
			end
		end else if (head.count == CNT_FOUR && ext22) begin
			code = SHAPE_2X2;
		end else begin
			code = by_ext;
		end
	end

	// Take a summary when the output register is free or being emptied.
	assign pop = !q_stat.empty && (!out_valid_q || !out_stall);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			code_q      <= SHAPE_NONE;
		end else if (pop) begin
			out_valid_q <= 1'b1;
			code_q      <= code;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign shape_code = code_q;

	// A single-pixel cluster always comes out as single.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.count == CNT_ONE) |=> (code_q == SHAPE_SINGLE))
		else $error("single pixel misclassified");

	// A valid result never carries the none code.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid_q |-> (code_q != SHAPE_NONE))
		else $error("none code emitted");

	// A summary is never popped while a stalled result is still held.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !pop)
		else $error("result overwritten while stalled");

endmodule

// ----- rtl/core/pixel_cluster_shape_classifier.sv -----
// Pixel cluster shape classifier (top level).
// Channels: pixels enter on in_valid/in_stall with pixel_u, pixel_v, last_pixel;
// one shape code per cluster leaves on out_valid/out_stall with shape_code.
// A transaction completes at a rising edge with valid high and stall low.
// Every pixel transaction updates the cluster accumulators; only the
// transaction with last_pixel set produces a result.
// Throughput: one pixel per cycle while the summary queue is not full; clusters of any length
// including single pixels may follow back to back.
// A finished cluster summary is written into the summary queue and classified
// from there into the output register, where the shape code turns valid.
// When the receiver stalls, the code holds in the output register and up to
// four finished cluster summaries wait in the queue; in_stall rises only when
// that queue is full, which sets the depth of output back pressure absorbed.
// Reset (arst_n low) empties the queue, drops any held result and clears the
// partial cluster being accumulated.
// Depends on pcsc_pkg, pcsc_front, pcsc_queue, pcsc_back.
module pixel_cluster_shape_classifier
	import pcsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [U_BITS-1:0] pixel_u,
	input  logic [V_BITS-1:0] pixel_v,
	input  logic              last_pixel,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        shape_code
);

	queue_stat_t  q_stat;
	logic         push;
	logic         pop;
	cluster_sum_t push_sum;
	cluster_sum_t head;

	// Accumulation of the incoming cluster.
	pcsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.pixel_u  (pixel_u),
		.pixel_v  (pixel_v),
		.last_pixel(last_pixel),
		.q_stat   (q_stat),
		.push     (push),
		.push_sum (push_sum)
	);

	// Finished cluster summaries.
	pcsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_sum (push_sum),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	// Classification and result register.
	pcsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.shape_code (shape_code)
	);

endmodule
